// ----- design/csv_field_splitter_core_defines.svh -----
// assertion macros for the csv field splitter
`ifndef CSV_FIELD_SPLITTER_CORE_DEFINES_SVH
`define CSV_FIELD_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CSV_FS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CSV_FS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/csv_fs_pkg.sv -----
// shared types and constants of the csv field splitter
package csv_fs_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned RES_CNT_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 1'b1;

  localparam logic [BYTE_W-1:0] SEP_RESET   = 8'd44;
  localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

  localparam logic [BYTE_W-1:0] CH_NUL = 8'd0;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;

  // one output word
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              content;
    logic              rec_end;
  } res_t;

  // all words caused by one input word, packed from slot 0 up
  typedef struct packed {
    logic [RES_CNT_W-1:0]     cnt;
    res_t [MAX_RES-1:0]       res;
  } entry_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- design/csv_fs_front.sv -----
// front end: config registers, line state and byte classification
module csv_fs_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [csv_fs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [csv_fs_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                             fire_i,
  input  logic [csv_fs_pkg::BYTE_W-1:0]    byte_i,
  input  logic                             has_byte_i,
  input  logic                             line_end_i,
  output logic                             push_o,
  output csv_fs_pkg::entry_t               entry_o
);
  import csv_fs_pkg::*;

  typedef struct packed {
    logic in_quotes;
    logic odd;
    logic field_empty;
    logic stopped;
  } line_st_t;

  typedef struct packed {
    line_st_t st;
    logic     emit;
    res_t     res;
  } dec_t;

  localparam line_st_t LINE_RESET = '{in_quotes: 1'b0, odd: 1'b0,
                                      field_empty: 1'b1, stopped: 1'b0};

  function automatic logic is_stop(input logic [BYTE_W-1:0] c);
    return c inside {CH_NUL, CH_LF, CH_CR};
  endfunction

  function automatic dec_t decide(input line_st_t st, input logic [BYTE_W-1:0] c,
                                  input logic at_end, input logic [BYTE_W-1:0] nxt,
                                  input logic [BYTE_W-1:0] sep,
                                  input logic [BYTE_W-1:0] quote);
    dec_t d;
    logic keep;
    logic closes;
    d      = '{st: st, emit: 1'b0, res: '0};
    keep   = 1'b0;
    closes = at_end || (nxt == sep) || is_stop(nxt);
    if (!st.stopped) begin
      if (st.field_empty && (c == quote)) begin
        // opening or closing quote at the start of a field
        d.st.in_quotes = !st.in_quotes;
        d.st.odd       = 1'b0;
      end else if (st.in_quotes) begin
        keep = 1'b1;
        if (c == quote) begin
          if (!st.odd && closes) begin
            d.st.in_quotes = 1'b0;
            d.st.odd       = 1'b0;
            keep           = 1'b0;
          end else begin
            d.st.odd = !st.odd;
          end
        end
      end else if (c == sep) begin
        d.st.field_empty = 1'b1;
        d.emit           = 1'b1;
      end else if (is_stop(c)) begin
        d.st.stopped = 1'b1;
      end else begin
        keep = 1'b1;
      end
      if (keep) begin
        d.st.field_empty = 1'b0;
        d.emit           = 1'b1;
        d.res.data       = c;
        d.res.content    = 1'b1;
      end
    end
    return d;
  endfunction

  logic [BYTE_W-1:0] sep_q, quote_q;
  logic [BYTE_W-1:0] held_q, held_d;
  logic              held_vld_q, held_vld_d;
  line_st_t          st_q, st_d;

  dec_t              dec_a, dec_b;
  logic              a_en, b_en;
  line_st_t          st_mid;
  logic [BYTE_W-1:0] held_mid;
  logic              held_vld_mid;
  res_t              mark;
  entry_t            ent;
  logic [RES_CNT_W-1:0] n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SEP_RESET;
      quote_q <= QUOTE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEPARATOR: sep_q   <= cfg_data_i;
        CFG_QUOTE:     quote_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    // held byte decided against the incoming byte
    a_en         = has_byte_i && held_vld_q;
    dec_a        = decide(st_q, held_q, 1'b0, byte_i, sep_q, quote_q);
    st_mid       = a_en ? dec_a.st : st_q;
    held_mid     = has_byte_i ? byte_i : held_q;
    held_vld_mid = has_byte_i || held_vld_q;
    // at line end the newly held byte is decided against end of line
    b_en         = line_end_i && held_vld_mid;
    dec_b        = decide(st_mid, held_mid, 1'b1, '0, sep_q, quote_q);

    if (line_end_i) begin
      st_d       = LINE_RESET;
      held_d     = '0;
      held_vld_d = 1'b0;
    end else begin
      st_d       = st_mid;
      held_d     = held_mid;
      held_vld_d = held_vld_mid;
    end

    mark = '{data: '0, content: 1'b0, rec_end: 1'b1};
    ent  = '0;
    n    = '0;
    if (a_en && dec_a.emit) begin
      ent.res[n] = dec_a.res;
      n          = n + 1'b1;
    end
    if (b_en && dec_b.emit) begin
      ent.res[n] = dec_b.res;
      n          = n + 1'b1;
    end
    if (line_end_i) begin
      ent.res[n] = mark;
      n          = n + 1'b1;
    end
    ent.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= LINE_RESET;
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else if (fire_i) begin
      st_q       <= st_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
    end
  end

  assign push_o  = fire_i && (ent.cnt != '0);
  assign entry_o = ent;

endmodule

// ----- design/csv_fs_queue.sv -----
// small entry queue between front and back end
module csv_fs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csv_fs_pkg::entry_t  entry_i,
  input  logic                pop_i,
  output csv_fs_pkg::entry_t  entry_o,
  output csv_fs_pkg::q_stat_t stat_o
);
  import csv_fs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  function automatic logic [PTR_W-1:0] nxt_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= nxt_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= nxt_ptr(rd_ptr_q);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/csv_fs_back.sv -----
// back end: steps through the words of one entry onto the output stream
module csv_fs_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            avail_i,
  input  csv_fs_pkg::entry_t              entry_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [csv_fs_pkg::BYTE_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import csv_fs_pkg::*;

  entry_t               cur_q;
  logic                 vld_q;
  logic [RES_CNT_W-1:0] idx_q;
  res_t                 res;
  logic                 last_slot, fire, done, load;

  assign res       = cur_q.res[idx_q];
  assign last_slot = (idx_q == (cur_q.cnt - 1'b1));
  assign fire      = vld_q && m_axis_tready;
  assign done      = fire && last_slot;
  assign load      = avail_i && (!vld_q || done);
  assign pop_o     = load;

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (done) begin
      vld_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = res.data;
  assign m_axis_tuser  = res.content;
  assign m_axis_tlast  = res.rec_end;

endmodule

// ----- design/csv_field_splitter_core.sv -----
// top level of the csv field splitter: front end, entry queue, back end
//
//  channel  | dir | tdata         | tuser      | tlast
//  ---------+-----+---------------+------------+-----------
//  s_axis   | in  | in_byte [7:0] | has_byte   | line_end
//  m_axis   | out | out_byte[7:0] | is_content | record_end
//  cfg      | in  | cfg_we_i / cfg_idx_i / cfg_data_i (separator, quote)
//
// one input word is taken per cycle while the entry queue has room; each word
// turns into zero to three output words that leave one per cycle while the
// output port is ready, so the output port sets the rate; a word at line end
// may add up to two more. output words pass the entry queue and the back end.
// reset clears line state, the queue and the output stage; config returns to
// separator 44 and quote 34. either side may stall without blocking the other
// until the queue fills (QUEUE_DEPTH entries).
`include "csv_field_splitter_core_defines.svh"
module csv_field_splitter_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [csv_fs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [csv_fs_pkg::BYTE_W-1:0]    cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [csv_fs_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
  input  logic                             s_axis_tuser,   // [0] has_byte
  input  logic                             s_axis_tlast,
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [csv_fs_pkg::BYTE_W-1:0]    m_axis_tdata,   // [7:0] out_byte
  output logic                             m_axis_tuser,   // [0] is_content
  output logic                             m_axis_tlast
);
  import csv_fs_pkg::*;

  logic    s_fire;
  logic    push, pop;
  entry_t  front_entry, head_entry;
  q_stat_t q_stat;

  // front may take a word whenever the queue has a free entry
  assign s_axis_tready = !q_stat.full;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  csv_fs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (s_fire),
    .byte_i     (s_axis_tdata),
    .has_byte_i (s_axis_tuser),
    .line_end_i (s_axis_tlast),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  // words that produce no output never enter the queue
  csv_fs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  csv_fs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (!q_stat.empty),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a record end is always a boundary mark
  `CSV_FS_ASSERT_NOW(a_rec_end_is_mark, m_axis_tvalid && m_axis_tlast, !m_axis_tuser, "record end on content word")
  // boundary marks carry a zero byte
  `CSV_FS_ASSERT_NOW(a_mark_zero_data, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "mark with nonzero byte")
  // a line end always leaves work behind for the back end
  `CSV_FS_ASSERT_NEXT(a_line_end_queued, s_fire && s_axis_tlast, !q_stat.empty || m_axis_tvalid, "line end lost")

endmodule
